// File: src/swmrt_pkg.sv
// shared types and constants for the regime tracker
package swmrt_pkg;

  localparam int MaxRegimes = 16;
  localparam int MaxWindow  = 64;

  localparam logic [4:0]  RegimeCountRst    = 5'd4;
  localparam logic [6:0]  WindowLengthRst   = 7'd64;
  localparam logic [15:0] RangeLowRst       = 16'hF000;
  localparam logic [15:0] RangeHighRst      = 16'h1000;
  localparam logic [15:0] AlertThresholdRst = 16'h8000;

  localparam logic [2:0] RegRegimeCount    = 3'd0;
  localparam logic [2:0] RegWindowLength   = 3'd1;
  localparam logic [2:0] RegRangeLow       = 3'd2;
  localparam logic [2:0] RegRangeHigh      = 3'd3;
  localparam logic [2:0] RegAlertThreshold = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_QDIV,
    ST_EVICT_RD,
    ST_EVICT_WR,
    ST_INC_RD,
    ST_INC_WR,
    ST_SCAN,
    ST_PDIV,
    ST_DONE,
    ST_OUT
  } swmrt_state_t;

  typedef struct packed {
    logic clear_step;
    logic clear_all;
    logic qdiv_start;
    logic evict_rd;
    logic evict_wr;
    logic inc_rd;
    logic inc_wr;
    logic scan_start;
    logic scan_step;
    logic pdiv_start;
    logic pdiv_step;
    logic finish;
  } swmrt_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic qdiv_done;
    logic last_valid;
    logic ring_full;
    logic scan_done;
    logic row_nonzero;
    logic pdiv_done;
  } swmrt_stat_t;

endpackage

// File: src/sliding_window_markov_regime_tracker_unit.sv
// top level of the sliding window markov regime tracker
// usage:
//   input channel: bias_sample with in_valid / in_ready; one transfer per sample
//   output channel: regime and prediction fields with out_valid / out_ready
//   an item is taken only in idle; its result is offered after, in order:
//   a bit-serial quantiser divide (up to 22 steps), a read-modify-write of
//   the evicted (when the ring is full) and new counts, a row scan and a
//   24-step probability divide (if the row is nonzero) over the one count
//   matrix port; the result is held until out_ready; no new sample is taken
//   meanwhile; after reset, and after any register write, a clearing pass
//   over all MAX_REGIMES*MAX_REGIMES cells (256 by default) zeroes the count
//   matrix and the ring; no sample is accepted during it; registers live on
//   an apb port, to be written only while the block is idle, a rule on the
//   user that the block itself does not enforce; samples_seen counts samples
//   since the last reset or register write
module sliding_window_markov_regime_tracker_unit
  import swmrt_pkg::*;
#(
  parameter int MAX_REGIMES = MaxRegimes,
  parameter int MAX_WINDOW  = MaxWindow
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] bias_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [3:0]  regime_now,
  output logic        [3:0]  predicted_next,
  output logic        [15:0] predicted_prob,
  output logic               alert_fired,
  output logic        [3:0]  alert_from,
  output logic        [3:0]  alert_to,
  output logic        [31:0] samples_seen
);

  logic [4:0]  regime_count;
  logic [6:0]  window_length;
  logic [15:0] range_low;
  logic [15:0] range_high;
  logic [15:0] alert_threshold;
  logic        wr_en;
  logic        cfg_write;
  logic [2:0]  reg_idx;
  swmrt_cmd_t  cmd;
  swmrt_stat_t stat;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg_write = wr_en && reg_idx <= RegAlertThreshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      regime_count <= RegimeCountRst;
      window_length <= WindowLengthRst;
      range_low <= RangeLowRst;
      range_high <= RangeHighRst;
      alert_threshold <= AlertThresholdRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegRegimeCount:    regime_count <= pwdata[4:0];
        RegWindowLength:   window_length <= pwdata[6:0];
        RegRangeLow:       range_low <= pwdata[15:0];
        RegRangeHigh:      range_high <= pwdata[15:0];
        RegAlertThreshold: alert_threshold <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRegimeCount:    prdata = {27'd0, regime_count};
      RegWindowLength:   prdata = {25'd0, window_length};
      RegRangeLow:       prdata = {16'd0, range_low};
      RegRangeHigh:      prdata = {16'd0, range_high};
      RegAlertThreshold: prdata = {16'd0, alert_threshold};
      default:           prdata = '0;
    endcase
  end

  swmrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swmrt_datapath #(
    .MAX_REGIMES (MAX_REGIMES),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .regime_count    (regime_count),
    .window_length   (window_length),
    .range_low       (range_low),
    .range_high      (range_high),
    .alert_threshold (alert_threshold),
    .bias_sample     (bias_sample),
    .cmd             (cmd),
    .stat            (stat),
    .regime_now      (regime_now),
    .predicted_next  (predicted_next),
    .predicted_prob  (predicted_prob),
    .alert_fired     (alert_fired),
    .alert_from      (alert_from),
    .alert_to        (alert_to),
    .samples_seen    (samples_seen)
  );

endmodule

// File: src/swmrt_ctrl.sv
// sequencing state machine for the regime tracker
module swmrt_ctrl
  import swmrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  swmrt_stat_t stat,
  output swmrt_cmd_t  cmd
);

  swmrt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.qdiv_start = 1'b1;
          state_next = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (stat.qdiv_done) begin
          if (!stat.last_valid) begin
            state_next = ST_DONE;
          end else if (stat.ring_full) begin
            cmd.evict_rd = 1'b1;
            state_next = ST_EVICT_RD;
          end else begin
            cmd.inc_rd = 1'b1;
            state_next = ST_INC_RD;
          end
        end
      end
      ST_EVICT_RD: begin
        state_next = ST_EVICT_WR;
      end
      ST_EVICT_WR: begin
        cmd.evict_wr = 1'b1;
        cmd.inc_rd = 1'b1;
        state_next = ST_INC_RD;
      end
      ST_INC_RD: begin
        state_next = ST_INC_WR;
      end
      ST_INC_WR: begin
        cmd.inc_wr = 1'b1;
        cmd.scan_start = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          if (stat.row_nonzero) begin
            cmd.pdiv_start = 1'b1;
            state_next = ST_PDIV;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_PDIV: begin
        cmd.pdiv_step = 1'b1;
        if (stat.pdiv_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    if (cfg_write) begin
      cmd.clear_all = 1'b1;
      state_next = ST_CLEAR;
    end
  end

endmodule

// File: src/swmrt_datapath.sv
// quantiser, ring, count matrix, row scan and dividers
module swmrt_datapath
  import swmrt_pkg::*;
#(
  parameter int MAX_REGIMES = MaxRegimes,
  parameter int MAX_WINDOW  = MaxWindow
) (
  input  logic               clk,
  input  logic               rst,
  input  logic        [4:0]  regime_count,
  input  logic        [6:0]  window_length,
  input  logic signed [15:0] range_low,
  input  logic signed [15:0] range_high,
  input  logic        [15:0] alert_threshold,
  input  logic signed [15:0] bias_sample,
  input  swmrt_cmd_t         cmd,
  output swmrt_stat_t        stat,
  output logic        [3:0]  regime_now,
  output logic        [3:0]  predicted_next,
  output logic        [15:0] predicted_prob,
  output logic               alert_fired,
  output logic        [3:0]  alert_from,
  output logic        [3:0]  alert_to,
  output logic        [31:0] samples_seen
);

  localparam int RW = $clog2(MAX_REGIMES);
  localparam int WW = $clog2(MAX_WINDOW);
  localparam int MD = MAX_REGIMES * MAX_REGIMES;
  localparam int MW = $clog2(MD);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = CW + RW;

  // clamped configuration
  logic [RW:0] n;
  logic [CW-1:0] w;
  always_comb begin
    if (regime_count < 5'd2) begin
      n = (RW+1)'(2);
    end else if (32'(regime_count) > MAX_REGIMES) begin
      n = (RW+1)'(MAX_REGIMES);
    end else begin
      n = (RW+1)'(regime_count);
    end
    if (window_length < 7'd2) begin
      w = CW'(2);
    end else if (32'(window_length) > MAX_WINDOW) begin
      w = CW'(MAX_WINDOW);
    end else begin
      w = CW'(window_length);
    end
  end

  // memories
  logic [2*RW-1:0] ring_mem [MAX_WINDOW];
  logic [CW-1:0]   count_mem [MD];
  logic [2*RW-1:0] ring_rd;
  logic [CW-1:0]   count_rd;

  logic [MW:0]     clr_idx;
  logic [WW-1:0]   ring_head;
  logic [CW-1:0]   ring_fill;
  logic            last_valid;
  logic [RW-1:0]   last_regime;
  logic            alert_valid;
  logic [RW-1:0]   last_alert_target;
  logic [RW-1:0]   best_next;
  logic [15:0]     best_prob;
  logic [31:0]     sample_total;
  logic [RW-1:0]   cur;

  // quantiser divider: num = (bias-lo)*n, den = hi-lo
  logic [16:0] q_den;
  logic [16+RW:0] q_rem;
  logic [RW:0] q_quo;
  logic [4:0] q_cnt;
  logic q_busy, q_direct;
  logic [RW-1:0] q_direct_val;
  logic [16+RW+1:0] q_trial;
  logic [17+RW:0] q_num;

  assign q_trial = {q_rem, 1'b0};

  // scan and probability divider
  logic [RW:0] scan_j;
  logic [MW-1:0] scan_addr;
  logic scan_pend;
  logic [RW-1:0] scan_jd;
  logic [SW-1:0] row_sum;
  logic [CW-1:0] bc;
  logic [RW-1:0] bj;
  logic [CW+16:0] p_rem;
  logic [16:0] p_quo;
  logic [CW+16:0] p_num;
  logic [4:0] p_cnt;

  logic [MW-1:0] evict_addr, inc_addr;
  logic [MW-1:0] rw_addr;
  logic [MW-1:0] wr_addr_hold;
  logic [2*RW-1:0] head_entry;

  // ring entries are always below n, the ring being cleared on every change of n
  always_comb begin
    evict_addr = MW'(32'(ring_rd[2*RW-1:RW]) * 32'(n) + 32'(ring_rd[RW-1:0]));
    inc_addr = MW'(32'(last_regime) * 32'(n) + 32'(cur));
    scan_addr = MW'(32'(cur) * 32'(n) + 32'(scan_j));
    head_entry = {last_regime, cur};
  end

  // one address for reads of the count matrix
  always_comb begin
    if (cmd.evict_rd) begin
      rw_addr = evict_addr;
    end else if (cmd.inc_rd) begin
      rw_addr = inc_addr;
    end else if (cmd.scan_step) begin
      rw_addr = scan_addr;
    end else begin
      rw_addr = wr_addr_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      count_mem[clr_idx[MW-1:0]] <= '0;
      if (32'(clr_idx) < MAX_WINDOW) begin
        ring_mem[clr_idx[WW-1:0]] <= '0;
      end
    end else if (cmd.evict_wr) begin
      if (count_rd != '0) begin
        count_mem[wr_addr_hold] <= count_rd - CW'(1);
      end
    end else if (cmd.inc_wr) begin
      count_mem[wr_addr_hold] <= count_rd + CW'(1);
      ring_mem[ring_head] <= head_entry;
    end
    count_rd <= count_mem[rw_addr];
    ring_rd <= ring_mem[ring_head];
    if (cmd.evict_rd || cmd.inc_rd) begin
      wr_addr_hold <= rw_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      clr_idx <= '0;
    end else if (cmd.clear_step && 32'(clr_idx) < MD) begin
      clr_idx <= clr_idx + (MW+1)'(1);
    end
  end

  assign stat.clear_done = 32'(clr_idx) >= MD - 1;
  assign stat.last_valid = last_valid;
  assign stat.ring_full = ring_fill >= w;
  assign stat.qdiv_done = !q_busy;
  assign stat.scan_done = !scan_pend && 32'(scan_j) >= 32'(n) && !cmd.scan_start;
  assign stat.row_nonzero = bc != '0;
  assign stat.pdiv_done = p_cnt == 5'd0;

  logic [16:0] diff;
  always_comb begin
    diff = 17'(signed'({bias_sample[15], bias_sample}) - signed'({range_low[15], range_low}));
    q_den = 17'(signed'({range_high[15], range_high}) - signed'({range_low[15], range_low}));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all || cmd.clear_step) begin
      q_busy <= 1'b0;
      ring_head <= '0;
      ring_fill <= '0;
      last_valid <= 1'b0;
      last_regime <= '0;
      alert_valid <= 1'b0;
      last_alert_target <= '0;
      best_next <= '0;
      best_prob <= '0;
      sample_total <= '0;
      scan_pend <= 1'b0;
      p_cnt <= '0;
    end else begin
      if (cmd.qdiv_start) begin
        sample_total <= sample_total + 32'd1;
        if (range_high <= range_low || bias_sample <= range_low) begin
          q_direct <= 1'b1;
          q_direct_val <= '0;
          q_busy <= 1'b0;
        end else if (bias_sample >= range_high) begin
          q_direct <= 1'b1;
          q_direct_val <= RW'(n - (RW+1)'(1));
          q_busy <= 1'b0;
        end else begin
          q_direct <= 1'b0;
          q_busy <= 1'b1;
          q_rem <= '0;
          q_quo <= '0;
          q_cnt <= 5'(17 + RW + 1);
          q_num <= (17+RW+1)'(32'(diff) * 32'(n));
        end
      end else if (q_busy) begin
        if ({q_trial[16+RW:0] | (17+RW)'(q_num[17+RW])} >= (17+RW)'(q_den)) begin
          q_rem <= (17+RW)'({q_trial[16+RW:1], q_num[17+RW]} - (17+RW)'(q_den));
          q_quo <= {q_quo[RW-1:0], 1'b1};
        end else begin
          q_rem <= (17+RW)'({q_trial[16+RW:1], q_num[17+RW]});
          q_quo <= {q_quo[RW-1:0], 1'b0};
        end
        q_num <= {q_num[16+RW:0], 1'b0};
        q_cnt <= q_cnt - 5'd1;
        if (q_cnt == 5'd1) begin
          q_busy <= 1'b0;
        end
      end
      if (cmd.inc_wr) begin
        ring_head <= 32'(ring_head) + 32'd1 >= 32'(w) ? '0 : ring_head + WW'(1);
        if (ring_fill < w) begin
          ring_fill <= ring_fill + CW'(1);
        end
      end
      if (cmd.scan_start) begin
        scan_j <= '0;
        scan_pend <= 1'b1;
        row_sum <= '0;
        bc <= '0;
        bj <= '0;
      end else if (cmd.scan_step) begin
        if (32'(scan_j) < 32'(n)) begin
          scan_j <= scan_j + (RW+1)'(1);
          scan_jd <= RW'(scan_j);
          scan_pend <= 1'b1;
        end else begin
          scan_pend <= 1'b0;
        end
        if (scan_pend && scan_j != '0) begin
          row_sum <= row_sum + SW'(count_rd);
          if (count_rd > bc) begin
            bc <= count_rd;
            bj <= scan_jd;
          end
        end
      end
      if (cmd.pdiv_start) begin
        p_rem <= '0;
        p_quo <= '0;
        p_num <= {1'b0, bc, 16'd0};
        p_cnt <= 5'(CW + 17);
      end else if (cmd.pdiv_step && p_cnt != 5'd0) begin
        if ({p_rem[CW+15:0], p_num[CW+16]} >= (CW+17)'(row_sum)) begin
          p_rem <= {p_rem[CW+15:0], p_num[CW+16]} - (CW+17)'(row_sum);
          p_quo <= {p_quo[15:0], 1'b1};
        end else begin
          p_rem <= {p_rem[CW+15:0], p_num[CW+16]};
          p_quo <= {p_quo[15:0], 1'b0};
        end
        p_num <= {p_num[CW+15:0], 1'b0};
        p_cnt <= p_cnt - 5'd1;
      end
      if (cmd.finish) begin
        alert_fired <= 1'b0;
        alert_from <= '0;
        alert_to <= '0;
        regime_now <= 4'(cur);
        if (last_valid) begin
          if (bc != '0) begin
            best_next <= bj;
            best_prob <= p_quo[16] ? 16'hFFFF : p_quo[15:0];
            predicted_next <= 4'(bj);
            predicted_prob <= p_quo[16] ? 16'hFFFF : p_quo[15:0];
            if (48'({bc, 16'd0}) > 48'(alert_threshold) * 48'(row_sum)
                && (!alert_valid || last_alert_target != bj)) begin
              alert_fired <= 1'b1;
              alert_from <= 4'(cur);
              alert_to <= 4'(bj);
              alert_valid <= 1'b1;
              last_alert_target <= bj;
            end
          end else begin
            best_next <= '0;
            best_prob <= '0;
            predicted_next <= '0;
            predicted_prob <= '0;
          end
        end else begin
          predicted_next <= 4'(best_next);
          predicted_prob <= best_prob;
        end
        last_regime <= cur;
        last_valid <= 1'b1;
        samples_seen <= sample_total;
      end
    end
  end

  assign cur = q_direct ? q_direct_val : q_quo[RW-1:0];

endmodule
